// ===== sv/basr_pkg.sv =====
// Shared types and constants for the ADC serial reader.
`timescale 1ns / 1ps

package basr_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_ADDR_W      = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_READY_POLLS  = 1'd1;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned POLL_W   = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned BITCNT_W = 5;
  localparam int unsigned SAMPLE_W = 24;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;
  localparam logic [POLL_W-1:0] POLLS_RESET = 20'd500000;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_POLL    = 7'b0000010,
    PH_CONFIRM = 7'b0000100,
    PH_HIGH    = 7'b0001000,
    PH_LOW     = 7'b0010000,
    PH_XHIGH   = 7'b0100000,
    PH_XLOW    = 7'b1000000
  } phase_t;

endpackage

// ===== sv/bridge_adc_serial_reader.sv =====
// Top level: tick-driven serial reader for a 24-bit load-cell converter.
// The result word is registered and offered in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result channel takes words; the sequencer
//   and the half-period counter update in the same cycle the input word is accepted.
// Reset (rst_n low, synchronous): sequencer idle, counters and sample cleared,
//   half period 100 ticks, ready timeout 500000 polls, output channel empty.
`timescale 1ns / 1ps

module bridge_adc_serial_reader #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel, one word per clock tick of the pin interface
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] dout_level, [7:2] zero
  // result channel, one word per input word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] sck_level, [1] busy_res, [2] sample_valid,
                                  // [26:3] sample_word, [27] ready_timeout, [31:28] zero
  // configuration write port
  input  logic                             cfg_we,
  input  logic [basr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [basr_pkg::CFG_W-1:0]       cfg_wdata
);

  // Word width used to apply the offset-binary flip before keeping 24 bits
  localparam int unsigned EXT_W = (DATA_BITS > basr_pkg::SAMPLE_W) ?
                                  DATA_BITS : basr_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [basr_pkg::HALF_W-1:0] half_period_r;
  logic [basr_pkg::POLL_W-1:0] ready_polls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= basr_pkg::HALF_RESET;
      ready_polls_r <= basr_pkg::POLLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        basr_pkg::REG_HALF_PERIOD: half_period_r <= cfg_wdata[basr_pkg::HALF_W-1:0];
        basr_pkg::REG_READY_POLLS: ready_polls_r <= cfg_wdata[basr_pkg::POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  basr_pkg::phase_t              phase_r,   phase_nxt;
  logic [basr_pkg::HALF_W-1:0]   tick_r,    tick_nxt;
  logic [basr_pkg::POLL_W-1:0]   poll_r,    poll_nxt;
  logic [basr_pkg::BITCNT_W-1:0] bitcnt_r,  bitcnt_nxt;
  logic [DATA_BITS-1:0]          shift_r,   shift_nxt;
  logic                          tmo_r,     tmo_nxt;

  // Output register (skid between the two sides)
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic in_fire;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  logic start_req, dout_level;
  assign start_req  = in_tdata[0];
  assign dout_level = in_tdata[1];

  // Half-period counter: hp of zero behaves as one tick
  logic [basr_pkg::HALF_W-1:0] hp_eff;
  logic [basr_pkg::HALF_W:0]   tick_inc;
  logic                        half_done;
  assign hp_eff    = (half_period_r == '0) ? basr_pkg::HALF_W'(1) : half_period_r;
  assign tick_inc  = {1'b0, tick_r} + 1'b1;
  assign half_done = (tick_inc >= {1'b0, hp_eff});

  // Failed poll bookkeeping
  logic [basr_pkg::POLL_W-1:0] poll_inc;
  logic                        poll_expired;
  assign poll_inc     = poll_r + 1'b1;
  assign poll_expired = (poll_inc >= ready_polls_r);

  // Bit shifted in on the first low tick
  logic [DATA_BITS-1:0]          shift_in;
  logic [basr_pkg::BITCNT_W-1:0] bitcnt_inc;
  logic                          last_bit;
  assign shift_in   = {shift_r[DATA_BITS-2:0], dout_level};
  assign bitcnt_inc = bitcnt_r + 1'b1;

  // Result word: top data bit inverted, low 24 bits kept
  logic [EXT_W-1:0]              word_ext;
  logic [basr_pkg::SAMPLE_W-1:0] word_out;
  assign word_ext = EXT_W'(shift_r) ^ (EXT_W'(1) << (DATA_BITS - 1));
  assign word_out = word_ext[basr_pkg::SAMPLE_W-1:0];

  logic sck, busy, smp_valid, smp_tmo;

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    poll_nxt   = poll_r;
    bitcnt_nxt = bitcnt_r;
    shift_nxt  = shift_r;
    tmo_nxt    = tmo_r;
    smp_valid  = 1'b0;
    smp_tmo    = 1'b0;
    last_bit   = 1'b0;

    // pin and busy levels follow the phase at the start of the tick
    sck  = (phase_r == basr_pkg::PH_HIGH) || (phase_r == basr_pkg::PH_XHIGH);
    busy = (phase_r != basr_pkg::PH_IDLE);

    unique case (phase_r)
      basr_pkg::PH_POLL: begin
        if (!dout_level) begin
          phase_nxt = basr_pkg::PH_CONFIRM;
          tick_nxt  = '0;
        end else begin
          poll_nxt = poll_inc;
          if (poll_expired) begin
            tmo_nxt    = 1'b1;
            phase_nxt  = basr_pkg::PH_HIGH;
            tick_nxt   = '0;
            bitcnt_nxt = '0;
            shift_nxt  = '0;
          end
        end
      end
      basr_pkg::PH_CONFIRM: begin
        tick_nxt = half_done ? '0 : tick_inc[basr_pkg::HALF_W-1:0];
        if (half_done) begin
          if (!dout_level || poll_expired) begin
            // ready confirmed, or the failed recheck used up the poll budget
            tmo_nxt    = tmo_r | dout_level;
            phase_nxt  = basr_pkg::PH_HIGH;
            tick_nxt   = '0;
            bitcnt_nxt = '0;
            shift_nxt  = '0;
          end else begin
            phase_nxt = basr_pkg::PH_POLL;
          end
          if (dout_level) begin
            poll_nxt = poll_inc;
          end
        end
      end
      basr_pkg::PH_HIGH: begin
        tick_nxt = half_done ? '0 : tick_inc[basr_pkg::HALF_W-1:0];
        if (half_done) begin
          phase_nxt = basr_pkg::PH_LOW;
        end
      end
      basr_pkg::PH_LOW: begin
        if (tick_r == '0) begin
          shift_nxt  = shift_in;
          bitcnt_nxt = bitcnt_inc;
        end
        last_bit = ({1'b0, bitcnt_nxt} >= (basr_pkg::BITCNT_W + 1)'(DATA_BITS)) ||
                   (bitcnt_nxt == '0);
        tick_nxt = half_done ? '0 : tick_inc[basr_pkg::HALF_W-1:0];
        if (half_done) begin
          phase_nxt = last_bit ? basr_pkg::PH_XHIGH : basr_pkg::PH_HIGH;
        end
      end
      basr_pkg::PH_XHIGH: begin
        tick_nxt = half_done ? '0 : tick_inc[basr_pkg::HALF_W-1:0];
        if (half_done) begin
          phase_nxt = basr_pkg::PH_XLOW;
        end
      end
      basr_pkg::PH_XLOW: begin
        tick_nxt = half_done ? '0 : tick_inc[basr_pkg::HALF_W-1:0];
        if (half_done) begin
          smp_valid = 1'b1;
          smp_tmo   = tmo_r;
          phase_nxt = basr_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = basr_pkg::PH_IDLE;
        if (start_req) begin
          phase_nxt  = basr_pkg::PH_POLL;
          tick_nxt   = '0;
          poll_nxt   = '0;
          bitcnt_nxt = '0;
          shift_nxt  = '0;
          tmo_nxt    = 1'b0;
        end
      end
    endcase

    out_data_nxt = {4'd0, smp_tmo,
                    smp_valid ? word_out : {basr_pkg::SAMPLE_W{1'b0}},
                    smp_valid, busy, sck};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= basr_pkg::PH_IDLE;
      tick_r      <= '0;
      poll_r      <= '0;
      bitcnt_r    <= '0;
      shift_r     <= '0;
      tmo_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        poll_r   <= poll_nxt;
        bitcnt_r <= bitcnt_nxt;
        shift_r  <= shift_nxt;
        tmo_r    <= tmo_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
